/* rtl/core/prank_pkg.sv */
// types, constants and the factorial table shared by the permutation rank block
package prank_pkg;

   // permutation length, 1..13
   localparam int PERM_LENGTH = 8;

   localparam int SYM_W  = 8;
   localparam int RANK_W = 16;
   localparam int POS_W  = 4;
   localparam int CNT_W  = 4;
   localparam int FACT_W = 4;

   // one input word after the input register
   typedef struct packed {
      logic [SYM_W-1:0] symbol;
      logic             last;
      logic             empty_string;
   } prank_item_type;

   // running state of the string in progress
   typedef struct packed {
      logic [PERM_LENGTH-1:0] seen_set;
      logic [POS_W-1:0]       position;
      logic                   bad_string;
      logic [RANK_W-1:0]      rank_sum;
   } prank_state_type;

   // one result word
   typedef struct packed {
      logic [RANK_W-1:0] rank;
      logic              found;
   } prank_result_type;

   // factorial modulo 2^16, indexed by position
   function automatic logic [RANK_W-1:0] fact_mod(input logic [FACT_W-1:0] pos);
      logic [RANK_W-1:0] f;
      case (pos)
         4'd0:    f = 16'd1;
         4'd1:    f = 16'd1;
         4'd2:    f = 16'd2;
         4'd3:    f = 16'd6;
         4'd4:    f = 16'd24;
         4'd5:    f = 16'd120;
         4'd6:    f = 16'd720;
         4'd7:    f = 16'd5040;
         4'd8:    f = 16'd40320;
         4'd9:    f = 16'd35200;
         4'd10:   f = 16'd24320;
         4'd11:   f = 16'd5376;
         4'd12:   f = 16'd64512;
         default: f = 16'd0;
      endcase
      return f;
   endfunction

endpackage

/* rtl/core/permutation_rank.sv */
// permutation rank: factorial-base index of the inversion counts of a symbol string
// a last word passes the input register, then the output register, to give its result
// throughput: one word per cycle while no last word waits; prank_step is combinational
// a waiting result in the output register stalls the next last word and words behind it
// reset: synchronous, active high; clears the string state and both valid flags
module permutation_rank (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] symbol
   input  logic        req_tlast,   // last
   input  logic [0:0]  req_tuser,   // [0] empty_string
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] rank
   output logic [0:0]  rsp_tuser    // [0] found
);
   import prank_pkg::*;

   logic             in_valid_ff;
   prank_item_type   item_ff;
   prank_state_type  state_ff;
   prank_state_type  state_in;
   prank_result_type result_in;
   prank_result_type result_ff;
   logic             rsp_valid_ff;
   logic             go;

   // a word in the input register moves on unless it needs a full output slot
   assign go         = in_valid_ff && (!item_ff.last || !rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || go;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready) begin
         item_ff.symbol       <= req_tdata;
         item_ff.last         <= req_tlast;
         item_ff.empty_string <= req_tuser[0];
      end
   end

   prank_step u_step (
      .state_cur  (state_ff),
      .item       (item_ff),
      .state_next (state_in),
      .result     (result_in)
   );

   // string state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (go) begin
         state_ff <= state_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (go && item_ff.last) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (go && item_ff.last) begin
         result_ff <= result_in;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = result_ff.rank;
   assign rsp_tuser[0] = result_ff.found;

endmodule

/* rtl/core/prank_step.sv */
// combinational update of the string state for one word, and the result on last
module prank_step (
   input  prank_pkg::prank_state_type  state_cur,
   input  prank_pkg::prank_item_type   item,
   output prank_pkg::prank_state_type  state_next,
   output prank_pkg::prank_result_type result
);
   import prank_pkg::*;

   localparam logic [SYM_W-1:0] LEN_SYM = SYM_W'(PERM_LENGTH);
   localparam logic [POS_W-1:0] LEN_POS = POS_W'(PERM_LENGTH);

   logic [PERM_LENGTH-1:0] hit;
   logic [PERM_LENGTH-1:0] full_mask;
   logic [CNT_W-1:0]       greater;
   logic                   sym_ok;
   logic [RANK_W+CNT_W-1:0] term;
   prank_state_type        upd;
   logic                   ok;

   // one-hot of the symbol, count of seen values above it, mask of 1..position
   always_comb begin
      greater = '0;
      for (int i = 0; i < PERM_LENGTH; i++) begin
         hit[i]       = (item.symbol == SYM_W'(i + 1));
         full_mask[i] = (POS_W'(i) < upd.position);
         greater      = greater + CNT_W'(state_cur.seen_set[i] & (SYM_W'(i + 1) > item.symbol));
      end
   end

   assign sym_ok = (item.symbol != '0) && (item.symbol <= LEN_SYM);
   assign term   = greater * fact_mod(FACT_W'(state_cur.position));

   // element update
   always_comb begin
      upd = state_cur;
      if (!item.empty_string) begin
         if (state_cur.position >= LEN_POS) begin
            upd.bad_string = 1'b1;
         end else if (!sym_ok || ((state_cur.seen_set & hit) != '0)) begin
            upd.bad_string = 1'b1;
            upd.position   = state_cur.position + POS_W'(1);
         end else begin
            upd.rank_sum = state_cur.rank_sum + term[RANK_W-1:0];
            upd.seen_set = state_cur.seen_set | hit;
            upd.position = state_cur.position + POS_W'(1);
         end
      end
   end

   // result and clear at the end of a string
   assign ok           = !upd.bad_string && (upd.seen_set == full_mask);
   assign result.found = ok;
   assign result.rank  = ok ? upd.rank_sum : '0;
   assign state_next   = item.last ? prank_state_type'('0) : upd;

endmodule

/* rtl/core/prank_checker.sv */
// port-level checks for the permutation rank block, bound to the top level
module prank_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic [0:0]  rsp_tuser
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result word changed while stalled");

   // a string that is not found ranks zero
   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == 16'd0)
      else $error("nonzero rank on a string that was not found");

   // no result word right after reset
   a_reset_clear: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

   // a fresh result follows an accepted last word that has passed the input and output registers
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready && req_tlast, 2))
      else $error("result word without a last word");

endmodule

bind permutation_rank prank_checker u_prank_checker (.*);
